// ===== sv/tmse_pkg.sv =====
// Shared types and constants of the Turing machine step engine.
package tmse_pkg;

  localparam int unsigned TAPE_CELLS       = 1024;
  localparam int unsigned TAPE_AW          = 10;
  localparam int unsigned TRANSITION_SLOTS = 64;
  localparam int unsigned SLOT_AW          = 6;
  localparam int unsigned STATE_COUNT      = 64;
  localparam int unsigned STATE_W          = 6;
  localparam int unsigned SYM_W            = 8;
  localparam int unsigned TAPE_W           = SYM_W + 1;
  localparam int unsigned MASK_W           = 64;
  localparam int unsigned SLOTS_W          = 7;
  localparam int unsigned STATUS_W         = 3;

  localparam logic [1:0] OP_LOAD_SLOT = 2'd0;
  localparam logic [1:0] OP_LOAD_CELL = 2'd1;
  localparam logic [1:0] OP_STEP      = 2'd2;
  localparam logic [1:0] OP_RESTART   = 2'd3;

  localparam logic [1:0] MV_RIGHT = 2'd1;
  localparam logic [1:0] MV_LEFT  = 2'd2;

  localparam logic [1:0] CFG_BLANK = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_FINAL = 2'd2;
  localparam logic [1:0] CFG_SLOTS = 2'd3;

  localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_STEPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_ACCEPTED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NO_MATCH = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EDGE     = 3'd4;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   read_symbol;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   write_symbol;
    logic               do_write;
    logic [1:0]         head_move;
  } slot_t;

  typedef struct packed {
    logic                load_slot;
    logic                load_cell;
    logic                restart;
    logic                clr_step;
    logic                srch_start;
    logic                srch_step;
    logic                apply;
    logic                hread_cap;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic accepting;
    logic clr_last;
    logic hit;
    logic miss;
    logic at_edge;
    logic moved;
  } dp_sts_t;

endpackage

// ===== sv/tmse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tmse_dp.sv =====
// Datapath: configuration registers, tape and slot memories, head and state.
module tmse_dp
  import tmse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [MASK_W-1:0]   cfg_wdata_i,
  input  logic [SLOT_AW-1:0]  slot_index_i,
  input  logic [TAPE_AW-1:0]  cell_address_i,
  input  logic [STATE_W-1:0]  from_state_i,
  input  logic [SYM_W-1:0]    read_symbol_i,
  input  logic [STATE_W-1:0]  to_state_i,
  input  logic [SYM_W-1:0]    write_symbol_i,
  input  logic                do_write_i,
  input  logic [1:0]          head_move_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [STATE_W-1:0]  state_now_o,
  output logic [TAPE_AW-1:0]  head_now_o,
  output logic [SYM_W-1:0]    symbol_now_o
);

  logic [SYM_W-1:0]    blank_q;
  logic [STATE_W-1:0]  start_q;
  logic [MASK_W-1:0]   mask_q;
  logic [SLOTS_W-1:0]  slots_q;

  logic [STATE_W-1:0]  state_q;
  logic [TAPE_AW-1:0]  head_q;
  logic                head_wr_q;
  logic [SYM_W-1:0]    head_val_q;
  logic [TAPE_AW-1:0]  clr_idx_q;
  logic [SLOT_AW:0]    rd_idx_q;
  logic                cmp_vld_q;
  slot_t               slot_q;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [STATE_W-1:0]  state_out_q;
  logic [TAPE_AW-1:0]  head_out_q;
  logic [SYM_W-1:0]    sym_out_q;

  logic [SLOT_AW:0]    limit;
  logic                rd_more;
  logic [SYM_W-1:0]    cur_sym;
  slot_t               tbl_wdata;
  slot_t               tbl_rdata;
  logic [$bits(slot_t)-1:0] tbl_rraw;
  logic                hit;
  logic [TAPE_AW:0]    head_ext;
  logic [TAPE_AW:0]    nh;
  logic                at_edge;
  logic                moved;
  logic                tape_we;
  logic [TAPE_AW-1:0]  tape_waddr;
  logic [TAPE_W-1:0]   tape_wdata;
  logic [TAPE_W-1:0]   tape_rdata;

  assign limit   = (slots_q > SLOTS_W'(TRANSITION_SLOTS)) ? (SLOT_AW+1)'(TRANSITION_SLOTS)
                                                          : slots_q;
  assign rd_more = rd_idx_q < limit;
  assign cur_sym = head_wr_q ? head_val_q : blank_q;

  assign tbl_wdata = '{from_state:   from_state_i,
                       read_symbol:  read_symbol_i,
                       to_state:     to_state_i,
                       write_symbol: write_symbol_i,
                       do_write:     do_write_i,
                       head_move:    head_move_i};
  assign tbl_rdata = slot_t'(tbl_rraw);

  tmse_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(TRANSITION_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_slot),
    .waddr_i(slot_index_i),
    .wdata_i(tbl_wdata),
    .re_i   (cmd_i.srch_step && rd_more),
    .raddr_i(rd_idx_q[SLOT_AW-1:0]),
    .rdata_o(tbl_rraw)
  );

  assign hit = cmp_vld_q && (tbl_rdata.from_state == state_q)
                         && (tbl_rdata.read_symbol == cur_sym);

  assign head_ext = {1'b0, head_q};

  always_comb begin
    nh = head_ext;
    if (slot_q.head_move == MV_RIGHT) begin
      if (head_q == '0) begin
        nh = (TAPE_AW+1)'(1);
      end else if (head_q[0]) begin
        nh = head_ext + (TAPE_AW+1)'(2);
      end else begin
        nh = head_ext - (TAPE_AW+1)'(2);
      end
    end else if (slot_q.head_move == MV_LEFT) begin
      if (head_q == TAPE_AW'(1)) begin
        nh = '0;
      end else if (head_q[0]) begin
        nh = head_ext - (TAPE_AW+1)'(2);
      end else begin
        nh = head_ext + (TAPE_AW+1)'(2);
      end
    end
  end

  assign at_edge = nh >= (TAPE_AW+1)'(TAPE_CELLS);
  assign moved   = !at_edge && (nh[TAPE_AW-1:0] != head_q);

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head_q;
    tape_wdata = {1'b1, slot_q.write_symbol};
    if (cmd_i.load_cell) begin
      tape_we    = 1'b1;
      tape_waddr = cell_address_i;
      tape_wdata = {1'b1, write_symbol_i};
    end else if (cmd_i.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_idx_q;
      tape_wdata = '0;
    end else if (cmd_i.apply && slot_q.do_write) begin
      tape_we    = 1'b1;
    end
  end

  tmse_ram #(
    .WIDTH(TAPE_W),
    .DEPTH(TAPE_CELLS)
  ) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .re_i   (cmd_i.apply && moved),
    .raddr_i(nh[TAPE_AW-1:0]),
    .rdata_o(tape_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= '0;
      start_q <= '0;
      mask_q  <= '0;
      slots_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BLANK: blank_q <= cfg_wdata_i[SYM_W-1:0];
        CFG_START: start_q <= cfg_wdata_i[STATE_W-1:0];
        CFG_FINAL: mask_q  <= cfg_wdata_i;
        CFG_SLOTS: slots_q <= cfg_wdata_i[SLOTS_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      head_q     <= '0;
      head_wr_q  <= 1'b0;
      head_val_q <= '0;
      clr_idx_q  <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.restart) begin
        state_q   <= start_q;
        head_q    <= '0;
        head_wr_q <= 1'b0;
        clr_idx_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + TAPE_AW'(1);
      end
      if (cmd_i.load_cell && (cell_address_i == head_q)) begin
        head_wr_q  <= 1'b1;
        head_val_q <= write_symbol_i;
      end
      if (cmd_i.srch_start) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end
      if (cmd_i.srch_step) begin
        cmp_vld_q <= rd_more;
        if (rd_more) begin
          rd_idx_q <= rd_idx_q + (SLOT_AW+1)'(1);
        end
      end
      if (cmd_i.apply) begin
        state_q <= slot_q.to_state;
        if (!at_edge) begin
          head_q <= nh[TAPE_AW-1:0];
        end
        if (!moved && slot_q.do_write) begin
          head_wr_q  <= 1'b1;
          head_val_q <= slot_q.write_symbol;
        end
      end
      if (cmd_i.hread_cap) begin
        head_wr_q  <= tape_rdata[TAPE_W-1];
        head_val_q <= tape_rdata[SYM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_step && hit) begin
      slot_q <= tbl_rdata;
    end
    if (cmd_i.emit) begin
      status_q    <= cmd_i.status;
      state_out_q <= state_q;
      head_out_q  <= head_q;
      sym_out_q   <= cur_sym;
    end
  end

  assign sts_o = '{accepting: ({1'b0, state_q} < (STATE_W+1)'(STATE_COUNT))
                              && mask_q[state_q],
                   clr_last:  clr_idx_q == TAPE_AW'(TAPE_CELLS - 1),
                   hit:       hit,
                   miss:      !hit && !rd_more,
                   at_edge:   at_edge,
                   moved:     moved};

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign state_now_o  = state_out_q;
  assign head_now_o   = head_out_q;
  assign symbol_now_o = sym_out_q;

endmodule

// ===== sv/tmse_ctrl.sv =====
// Controller: sequences clearing, slot search, tape update and result strobe.
module tmse_ctrl
  import tmse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_HREAD = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic                from_op_q, from_op_d;
  logic [STATUS_W-1:0] status_q, status_d;

  assign busy = state_q != ST_IDLE;

  always_comb begin
    state_d   = state_q;
    from_op_d = from_op_q;
    status_d  = status_q;
    cmd_o     = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode_i)
            OP_LOAD_SLOT: begin
              cmd_o.load_slot = 1'b1;
              status_d = STS_DONE;
              state_d  = ST_DONE;
            end
            OP_LOAD_CELL: begin
              cmd_o.load_cell = 1'b1;
              status_d = STS_DONE;
              state_d  = ST_DONE;
            end
            OP_STEP: begin
              if (sts_i.accepting) begin
                status_d = STS_ACCEPTED;
                state_d  = ST_DONE;
              end else begin
                cmd_o.srch_start = 1'b1;
                state_d = ST_SRCH;
              end
            end
            OP_RESTART: begin
              cmd_o.restart = 1'b1;
              status_d  = STS_DONE;
              from_op_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = from_op_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_APPLY;
        end else if (sts_i.miss) begin
          status_d = STS_NO_MATCH;
          state_d  = ST_DONE;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.at_edge) begin
          status_d = STS_EDGE;
          state_d  = ST_DONE;
        end else begin
          status_d = STS_STEPPED;
          state_d  = sts_i.moved ? ST_HREAD : ST_DONE;
        end
      end
      ST_HREAD: begin
        cmd_o.hread_cap = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      from_op_q <= 1'b0;
      status_q  <= STS_DONE;
    end else begin
      state_q   <= state_d;
      from_op_q <= from_op_d;
      status_q  <= status_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_IDLE)
    else $error("result cycle not followed by idle");

  a_hit_applies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH && sts_i.hit) |=> state_q == ST_APPLY)
    else $error("slot match not applied");

  a_hread_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HREAD |-> $past(state_q) == ST_APPLY)
    else $error("head read without a move");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_RESTART) |=> state_q == ST_CLEAR)
    else $error("restart request did not start the tape clear");

endmodule

// ===== sv/turing_machine_step_engine.sv =====
// Top level of the single-tape Turing machine step engine.
//
//   channel  direction  handshake               payload
//   request  in         start high, busy low     opcode_i .. head_move_i
//   result   out        done_o, one cycle        status_o, state_now_o, head_now_o, symbol_now_o
//   config   in         cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// Slot and tape loads, and a step in an accepting state, go from idle straight to the result.
// A step reads the slot memory in order, one slot-memory read per cycle, over up to
// min(slots_in_use, 64) slots; a match is applied, plus a head read when the head moves.
// Restart sweeps the 1024-entry tape memory, one entry a cycle.
// After reset the same sweep runs with busy high before a request is taken.
// done_o marks each result for one cycle with no stall; a new request may be taken then.
module turing_machine_step_engine
  import tmse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode_i,
  input  logic [SLOT_AW-1:0]  slot_index_i,
  input  logic [TAPE_AW-1:0]  cell_address_i,
  input  logic [STATE_W-1:0]  from_state_i,
  input  logic [SYM_W-1:0]    read_symbol_i,
  input  logic [STATE_W-1:0]  to_state_i,
  input  logic [SYM_W-1:0]    write_symbol_i,
  input  logic                do_write_i,
  input  logic [1:0]          head_move_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [MASK_W-1:0]   cfg_wdata_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [STATE_W-1:0]  state_now_o,
  output logic [TAPE_AW-1:0]  head_now_o,
  output logic [SYM_W-1:0]    symbol_now_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tmse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .opcode_i(opcode_i),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  tmse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .slot_index_i  (slot_index_i),
    .cell_address_i(cell_address_i),
    .from_state_i  (from_state_i),
    .read_symbol_i (read_symbol_i),
    .to_state_i    (to_state_i),
    .write_symbol_i(write_symbol_i),
    .do_write_i    (do_write_i),
    .head_move_i   (head_move_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .state_now_o   (state_now_o),
    .head_now_o    (head_now_o),
    .symbol_now_o  (symbol_now_o)
  );

endmodule
